// ----- hw/rtl/ial_pkg.sv -----
// Shared types and constants for the indexed array list.
package ial_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int LIM_W  = 5;

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_EDIT   = 3'd2,
        FN_DELETE = 3'd3,
        FN_GET    = 3'd4,
        FN_FIND   = 3'd5
    } ial_func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } ial_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_WR,
        S_GET_CAP,
        S_RESULT
    } ial_state_t;

    typedef struct packed {
        logic [2:0]               func;
        logic [3:0]               position;
        logic signed [DATA_W-1:0] value;
    } ial_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [3:0]               found_position;
        logic [2:0]               status;
        logic [4:0]               entry_count;
        logic                     is_empty;
        logic                     is_full;
    } ial_rsp_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ial_mem_req_t;

endpackage

// ----- hw/rtl/ial_mem.sv -----
// Entry store: one write port, one registered read port.
module ial_mem (
    input  logic                                 clk,
    input  ial_pkg::ial_mem_req_t                mreq,
    output logic [ial_pkg::DATA_W-1:0]           rdata
);
    import ial_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.re)
        begin
            rdata <= mem[mreq.raddr];
        end
    end

endmodule

// ----- hw/rtl/indexed_array_list_top.sv -----
// Top level of the indexed array list: request sequencer around the entry store.
//
//  channel | signals                     | direction | carries
//  --------+-----------------------------+-----------+---------------------------
//  req     | req_valid, req_ready, req   | in        | func, position, value
//  rsp     | rsp_valid, rsp_ready, rsp   | out       | one result beat per request
//  cfg     | cfg_we, cfg_wdata           | in        | capacity_limit, no wait
//
// One request is in flight at a time. Append, edit and refused requests go
// straight to the result state; get passes a read-capture state first.
// Insert, delete and find walk the store, one entry read per cycle; insert
// then writes the new value, and find stops at the first match.
// Reset clears the fill count, not the entries; entries are never read before written.
// A stalled rsp holds its beat; the next request is taken meanwhile, and its
// result waits in the sequencer until the output register frees up.
module indexed_array_list_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ial_pkg::ial_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ial_pkg::ial_rsp_t         rsp,
    input  logic                      cfg_we,
    input  logic [ial_pkg::LIM_W-1:0] cfg_wdata
);
    import ial_pkg::*;

    ial_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LIM_W-1:0]  lim_reg;
    logic [2:0]        func_reg, func_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0] rd_val_reg, rd_val_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    ial_status_t       status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    ial_rsp_t          out_reg, out_next;

    ial_mem_req_t      mreq;
    logic [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]  lim_eff;
    logic              full_now;
    logic              issue;
    logic [IDX_W-1:0]  scan_raddr;
    logic [IDX_W-1:0]  scan_waddr;
    logic [CNT_W-1:0]  scan_cur;
    logic              match;

    ial_mem u_mem (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    // a limit of zero acts as one, above the depth acts as the depth
    always_comb
    begin
        if (lim_reg == '0)
            lim_eff = CNT_W'(1);
        else if (lim_reg > LIM_W'(DEPTH))
            lim_eff = CNT_W'(DEPTH);
        else
            lim_eff = CNT_W'(lim_reg);
    end

    assign full_now = (count_reg >= lim_eff) || (count_reg >= CNT_W'(DEPTH));

    // walk step per mode: insert moves down from the end, delete and find move up
    always_comb
    begin
        issue      = 1'b0;
        scan_raddr = '0;
        scan_waddr = '0;
        scan_cur   = cur_reg;
        case (func_reg)
            FN_INSERT:
            begin
                issue      = cur_reg > CNT_W'(pos_reg);
                scan_raddr = IDX_W'(cur_reg - CNT_W'(1));
                scan_waddr = IDX_W'(cur_reg);
                scan_cur   = cur_reg - CNT_W'(1);
            end
            FN_DELETE:
            begin
                issue      = (cur_reg + CNT_W'(1)) < count_reg;
                scan_raddr = IDX_W'(cur_reg + CNT_W'(1));
                scan_waddr = IDX_W'(cur_reg);
                scan_cur   = cur_reg + CNT_W'(1);
            end
            FN_FIND:
            begin
                issue      = cur_reg < count_reg;
                scan_raddr = IDX_W'(cur_reg);
                scan_waddr = IDX_W'(cur_reg);
                scan_cur   = cur_reg + CNT_W'(1);
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign match = pend_reg && (func_reg == FN_FIND) && (rdata == val_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        rd_val_next    = rd_val_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        mreq           = '0;
        req_ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next   = req.func;
                    pos_next    = req.position;
                    val_next    = req.value;
                    rd_val_next = '0;
                    found_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                    case (req.func)
                        FN_APPEND:
                        begin
                            if (full_now)
                                status_next = ST_FULL;
                            else
                            begin
                                mreq.we    = 1'b1;
                                mreq.waddr = IDX_W'(count_reg);
                                mreq.wdata = req.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_INSERT:
                        begin
                            if (full_now)
                                status_next = ST_FULL;
                            else if (CNT_W'(req.position) > count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                cur_next   = count_reg;
                                state_next = S_SCAN;
                            end
                        end
                        FN_EDIT:
                        begin
                            if (CNT_W'(req.position) >= count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                mreq.we    = 1'b1;
                                mreq.waddr = req.position;
                                mreq.wdata = req.value;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else if (CNT_W'(req.position) >= count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                cur_next   = CNT_W'(req.position);
                                state_next = S_SCAN;
                            end
                        end
                        FN_GET:
                        begin
                            if (CNT_W'(req.position) >= count_reg)
                                status_next = ST_BAD_INDEX;
                            else
                            begin
                                mreq.re    = 1'b1;
                                mreq.raddr = req.position;
                                state_next = S_GET_CAP;
                            end
                        end
                        FN_FIND:
                        begin
                            status_next = ST_NOT_FOUND;
                            cur_next    = '0;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // data read last cycle lands now: shift it, or compare it
                if (pend_reg && (func_reg != FN_FIND))
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = pend_addr_reg;
                    mreq.wdata = rdata;
                end
                if (match)
                begin
                    found_next  = pend_addr_reg;
                    status_next = ST_OK;
                    state_next  = S_RESULT;
                end
                else if (issue)
                begin
                    mreq.re        = 1'b1;
                    mreq.raddr     = scan_raddr;
                    pend_next      = 1'b1;
                    pend_addr_next = scan_waddr;
                    cur_next       = scan_cur;
                end
                else
                begin
                    case (func_reg)
                        FN_INSERT:
                        begin
                            state_next = S_INS_WR;
                        end
                        FN_DELETE:
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_INS_WR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg;
                mreq.wdata = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESULT;
            end

            S_GET_CAP:
            begin
                rd_val_next = rdata;
                state_next  = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.read_value    = rd_val_reg;
                    out_next.found_position = found_reg;
                    out_next.status        = status_reg;
                    out_next.entry_count   = count_reg;
                    out_next.is_empty      = (count_reg == '0);
                    out_next.is_full       = (count_reg >= lim_eff);
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lim_reg       <= LIM_W'(16);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                lim_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        pend_addr_reg <= pend_addr_next;
        rd_val_reg    <= rd_val_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // shifting never reads and writes the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mreq.we && mreq.re) |-> (mreq.waddr != mreq.raddr))
        else $error("read and write hit the same entry");

    // one request at a time: an accepted beat closes the request side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while busy");

    // a result beat's empty flag agrees with its count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
        else $error("empty flag disagrees with count");

endmodule
